/* rtl/grouped_int8_quant_dot_product_top_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the grouped int8 quantised dot product
// Concurrent checks that are compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef GROUPED_INT8_QUANT_DOT_PRODUCT_TOP_DEFINES_SVH
`define GROUPED_INT8_QUANT_DOT_PRODUCT_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define GQ_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("gqdot assertion failed");
`define GQ_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("gqdot assertion failed");
`else
`define GQ_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons)
`define GQ_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons)
`endif

`endif

/* rtl/gqdot_pkg.sv */
// ----------------------------------------------------------------------------
// gqdot_pkg
// Types and constants shared by the grouped quantised dot product modules.
// ----------------------------------------------------------------------------
`default_nettype none

package gqdot_pkg;

    localparam int LANES   = 4;
    localparam int PSUM_W  = 18;
    localparam int SCALE_W = 20;
    localparam int GACC_W  = 32;
    localparam int ROW_W   = 56;
    localparam int PROD_W  = GACC_W + SCALE_W + 1;

    localparam logic [1:0] FMT_Q8 = 2'd0;
    localparam logic [1:0] FMT_Q6 = 2'd1;
    localparam logic [1:0] FMT_Q4 = 2'd2;

    localparam logic signed [ROW_W-1:0] ROW_MAX = {1'b0, {(ROW_W-1){1'b1}}};
    localparam logic signed [ROW_W-1:0] ROW_MIN = {1'b1, {(ROW_W-1){1'b0}}};

    typedef struct packed {
        logic signed [7:0]  act_0;
        logic signed [7:0]  act_1;
        logic signed [7:0]  act_2;
        logic signed [7:0]  act_3;
        logic [31:0]        weight_word;
        logic [2:0]         valid_count;
        logic [15:0]        weight_scale;
        logic [15:0]        act_scale;
        logic               group_end;
        logic               row_end;
    } in_item_t;

    typedef struct packed {
        logic signed [ROW_W-1:0] row_sum;
        logic                    saturated;
    } out_item_t;

    // One classified chunk as it travels from the front part to the back part.
    typedef struct packed {
        logic signed [PSUM_W-1:0] psum;
        logic [SCALE_W-1:0]       scale;
        logic                     close;
        logic                     row_end;
    } q_entry_t;

endpackage

`default_nettype wire

/* rtl/gqdot_front.sv */
// ----------------------------------------------------------------------------
// gqdot_front
// Decodes the packed weights, forms the lane products and the combined scale.
// ----------------------------------------------------------------------------
`default_nettype none

module gqdot_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire gqdot_pkg::in_item_t req_data,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_data,
    input  wire logic               q_full,
    output logic                    push,
    output gqdot_pkg::q_entry_t     push_entry
);
    import gqdot_pkg::*;

    logic [1:0]               fmt_reg;
    logic [1:0]               fmt_next;
    logic signed [7:0]        acts [LANES];
    logic signed [7:0]        wts [LANES];
    logic signed [15:0]       prods [LANES];
    logic signed [PSUM_W-1:0] psum;
    logic [31:0]              scale_prod;

    assign fmt_next = cfg_we ? cfg_data : fmt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= FMT_Q8;
        end
        else
        begin
            fmt_reg <= fmt_next;
        end
    end

    assign acts[0] = req_data.act_0;
    assign acts[1] = req_data.act_1;
    assign acts[2] = req_data.act_2;
    assign acts[3] = req_data.act_3;

    always_comb
    begin
        psum = '0;
        for (int k = 0; k < LANES; k++)
        begin
            unique case (fmt_reg)
                FMT_Q8:  wts[k] = $signed(req_data.weight_word[8*k +: 8]);
                FMT_Q6:  wts[k] = 8'($signed(req_data.weight_word[6*k +: 6]));
                FMT_Q4:  wts[k] = 8'($signed(req_data.weight_word[4*k +: 4]));
                default: wts[k] = '0;
            endcase
            prods[k] = acts[k] * wts[k];
            // Counts above the lane total simply enable every lane.
            if (3'(k) < req_data.valid_count)
            begin
                psum = psum + PSUM_W'(prods[k]);
            end
        end
    end

    assign scale_prod = 32'(req_data.weight_scale) * 32'(req_data.act_scale);

    assign req_stall          = q_full;
    assign push               = req_valid && !q_full;
    assign push_entry.psum    = psum;
    assign push_entry.scale   = scale_prod[31:12];
    assign push_entry.close   = req_data.group_end || req_data.row_end;
    assign push_entry.row_end = req_data.row_end;

endmodule

`default_nettype wire

/* rtl/gqdot_queue.sv */
// ----------------------------------------------------------------------------
// gqdot_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module gqdot_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire gqdot_pkg::q_entry_t push_entry,
    input  wire logic               pop,
    output logic                    full,
    output logic                    not_empty,
    output gqdot_pkg::q_entry_t     head
);
    import gqdot_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    q_entry_t         slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        priority if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

/* rtl/gqdot_back.sv */
// ----------------------------------------------------------------------------
// gqdot_back
// Group accumulation, group scaling and the saturating row accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

`include "grouped_int8_quant_dot_product_top_defines.svh"

module gqdot_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    input  wire gqdot_pkg::q_entry_t head,
    output logic                    pop,
    output logic                    res_valid,
    input  wire logic               res_stall,
    output gqdot_pkg::out_item_t    res_data
);
    import gqdot_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MUL  = 3'b010,
        ST_ADD  = 3'b100
    } back_state_t;

    back_state_t              state_reg;
    back_state_t              state_next;
    logic [GACC_W-1:0]        gacc_reg;
    logic [GACC_W-1:0]        gacc_next;
    logic [GACC_W-1:0]        gsum;
    logic [GACC_W-1:0]        gclose_reg;
    logic [SCALE_W-1:0]       scale_reg;
    logic                     rend_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod;
    logic signed [ROW_W-1:0]  row_acc_reg;
    logic signed [ROW_W-1:0]  row_acc_next;
    logic                     clip_reg;
    logic                     clip_next;
    logic signed [ROW_W:0]    wide_sum;
    logic                     clipped;
    logic signed [ROW_W-1:0]  sat_sum;
    logic                     out_free;
    logic                     emit;
    logic                     res_valid_reg;
    logic                     res_valid_next;
    out_item_t                res_data_reg;

    assign gsum = gacc_reg + GACC_W'(head.psum);
    assign prod = $signed(gclose_reg) * $signed({1'b0, scale_reg});

    assign wide_sum = {row_acc_reg[ROW_W-1], row_acc_reg} + (ROW_W + 1)'(prod_reg);
    assign clipped  = wide_sum[ROW_W] ^ wide_sum[ROW_W-1];
    assign sat_sum  = !clipped ? wide_sum[ROW_W-1:0] : (wide_sum[ROW_W] ? ROW_MIN : ROW_MAX);

    assign out_free = !res_valid_reg || !res_stall;
    assign pop      = (state_reg == ST_IDLE) && q_valid;
    assign emit     = (state_reg == ST_ADD) && rend_reg && out_free;

    always_comb
    begin
        state_next   = state_reg;
        gacc_next    = gacc_reg;
        row_acc_next = row_acc_reg;
        clip_next    = clip_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (head.close)
                    begin
                        gacc_next  = '0;
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        gacc_next = gsum;
                    end
                end
            end
            ST_MUL:
            begin
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                if (!rend_reg)
                begin
                    row_acc_next = sat_sum;
                    clip_next    = clip_reg || clipped;
                    state_next   = ST_IDLE;
                end
                else if (out_free)
                begin
                    row_acc_next = '0;
                    clip_next    = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg && res_stall;
        if (emit)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gacc_reg      <= '0;
            row_acc_reg   <= '0;
            clip_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gacc_reg      <= gacc_next;
            row_acc_reg   <= row_acc_next;
            clip_reg      <= clip_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head.close)
        begin
            gclose_reg <= gsum;
            scale_reg  <= head.scale;
            rend_reg   <= head.row_end;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= prod;
        end
        if (emit)
        begin
            res_data_reg.row_sum   <= sat_sum;
            res_data_reg.saturated <= clip_reg || clipped;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    `GQ_ASSERT_NXT(a_mul_then_add, clk, rst_n, state_reg == ST_MUL, state_reg == ST_ADD)
    `GQ_ASSERT_IMP(a_result_from_add, clk, rst_n, $rose(res_valid_reg), $past(state_reg == ST_ADD))
    `GQ_ASSERT_NXT(a_row_cleared, clk, rst_n, emit, (row_acc_reg == '0) && !clip_reg)

endmodule

`default_nettype wire

/* rtl/grouped_int8_quant_dot_product_top.sv */
// ----------------------------------------------------------------------------
// Grouped int8 quantised dot product
// Each request carries four int8 activations and one packed weight word
// (int8, packed 6-bit or packed 4-bit, chosen by the format register) and is
// accepted while the queue has room. The front part decodes the weights and
// forms the lane products and the Q8.12 group scale; a queue of QUEUE_DEPTH
// entries hands them to the back part. The back part handles a chunk that
// does not close a group in its idle state alone; a chunk that closes a group
// or a row passes through the idle, multiply and add states (group add, scale
// multiply, saturating row add) before the next chunk is taken. Within a
// group the sustained rate is one request per cycle while the queue has room.
// A row end emits the Q44.12 row sum in the cycle after the row add, through
// an output register that holds it while the result side stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module grouped_int8_quant_dot_product_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire gqdot_pkg::in_item_t req_data,
    output logic                    res_valid,
    input  wire logic               res_stall,
    output gqdot_pkg::out_item_t    res_data,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_data
);
    import gqdot_pkg::*;

    logic     q_full;
    logic     q_not_empty;
    logic     push;
    logic     pop;
    q_entry_t push_entry;
    q_entry_t head;

    gqdot_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_data   (req_data),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    gqdot_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .head       (head)
    );

    gqdot_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_not_empty),
        .head      (head),
        .pop       (pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule

`default_nettype wire
